/* hdl/rm2tu_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, angle constants and the arctangent table of the theta-u converter.
package rm2tu_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int IN_W         = 18;
	localparam int OUT_W        = 19;
	localparam int D_W          = 19;
	localparam int SQ_W         = 37;
	localparam int RAD_W        = 40;
	localparam int ROOT_W       = 20;
	localparam int SQRT_STEPS   = 20;
	localparam int X_W          = 38;
	localparam int Z_W          = 34;
	localparam int TH_W         = 32;
	localparam int DVD_W        = 60;
	localparam int DVS_W        = 20;
	localparam int REM_W        = 20;
	localparam int DIV_STEPS    = 40;
	localparam int MAG_W        = 53;
	localparam int GSHIFT       = 30 - FRAC_BITS;
	localparam int NSHIFT       = GSHIFT + 20;
	localparam int ONE          = 1 << FRAC_BITS;

	localparam logic [TH_W-1:0] PI_Q30      = 32'd3373259426;
	localparam logic [TH_W-1:0] HALF_PI_Q30 = 32'd1686629713;

	localparam longint LIM_RND = (longint'(PI_Q30) + (longint'(1) << (GSHIFT - 1))) >> GSHIFT;
	localparam longint FMAX    = (longint'(1) << (OUT_W - 1)) - 1;
	localparam logic [OUT_W-2:0] TU_MAX = (OUT_W-1)'((LIM_RND > FMAX) ? FMAX : LIM_RND);

	// atan(2^-i) in Q30, rounded to nearest
	function automatic logic [TH_W-1:0] atan_q30(input logic [4:0] i);
		logic [TH_W-1:0] v;
		case (i)
			5'd0:  v = 32'd843314857;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043837;
			5'd3:  v = 32'd133525159;
			5'd4:  v = 32'd67021687;
			5'd5:  v = 32'd33543516;
			5'd6:  v = 32'd16775851;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194283;
			5'd9:  v = 32'd2097149;
			5'd31: v = 32'd0;
			default: v = 32'd1 << (5'd30 - i);
		endcase
		return v;
	endfunction

endpackage

/* hdl/rm2tu_sqrt_cell.sv */
`timescale 1ns / 1ps
// One digit of a pipelined integer square root: decide result bit k.
module rm2tu_sqrt_cell (
	input  logic                            clk,
	input  logic [4:0]                      k,
	input  logic [rm2tu_pkg::RAD_W-1:0]     rem_i,
	input  logic [rm2tu_pkg::ROOT_W-1:0]    root_i,
	output logic [rm2tu_pkg::RAD_W-1:0]     rem_o,
	output logic [rm2tu_pkg::ROOT_W-1:0]    root_o
);
	import rm2tu_pkg::*;

	logic [RAD_W+1:0] trial;
	logic             take;

	// (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
	always_comb begin
		trial = ((RAD_W+2)'(root_i) << (k + 5'd1)) + ((RAD_W+2)'(1) << (2 * k));
		take  = {2'b00, rem_i} >= trial;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_o  <= rem_i - trial[RAD_W-1:0];
			root_o <= root_i | (ROOT_W'(1) << k);
		end else begin
			rem_o  <= rem_i;
			root_o <= root_i;
		end
	end

endmodule

/* hdl/rm2tu_cordic_cell.sv */
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation toward y = 0.
module rm2tu_cordic_cell (
	input  logic                              clk,
	input  logic [4:0]                        i,
	input  logic signed [rm2tu_pkg::X_W-1:0]  x_i,
	input  logic signed [rm2tu_pkg::X_W-1:0]  y_i,
	input  logic signed [rm2tu_pkg::Z_W-1:0]  z_i,
	output logic signed [rm2tu_pkg::X_W-1:0]  x_o,
	output logic signed [rm2tu_pkg::X_W-1:0]  y_o,
	output logic signed [rm2tu_pkg::Z_W-1:0]  z_o
);
	import rm2tu_pkg::*;

	logic signed [X_W-1:0] xs, ys;
	logic signed [Z_W-1:0] ang;

	always_comb begin
		xs  = x_i >>> i;
		ys  = y_i >>> i;
		ang = $signed(Z_W'(atan_q30(i)));
	end

	// hold when y is already exactly zero
	always_ff @(posedge clk) begin
		if (y_i > 0) begin
			x_o <= x_i + ys;
			y_o <= y_i - xs;
			z_o <= z_i + ang;
		end else if (y_i < 0) begin
			x_o <= x_i - ys;
			y_o <= y_i + xs;
			z_o <= z_i - ang;
		end else begin
			x_o <= x_i;
			y_o <= y_i;
			z_o <= z_i;
		end
	end

endmodule

/* hdl/rm2tu_div_cell.sv */
`timescale 1ns / 1ps
// One restoring division step: shift in a dividend bit, emit a quotient bit.
module rm2tu_div_cell (
	input  logic                             clk,
	input  logic [rm2tu_pkg::REM_W-1:0]      rem_i,
	input  logic [rm2tu_pkg::DIV_STEPS-1:0]  lo_i,
	input  logic [rm2tu_pkg::DVS_W-1:0]      dvs_i,
	output logic [rm2tu_pkg::REM_W-1:0]      rem_o,
	output logic [rm2tu_pkg::DIV_STEPS-1:0]  lo_o,
	output logic [rm2tu_pkg::DVS_W-1:0]      dvs_o
);
	import rm2tu_pkg::*;

	logic [REM_W:0] t, diff;
	logic           ge;

	always_comb begin
		t    = {rem_i, lo_i[DIV_STEPS-1]};
		diff = t - {1'b0, dvs_i};
		ge   = t >= {1'b0, dvs_i};
	end

	always_ff @(posedge clk) begin
		rem_o <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
		lo_o  <= {lo_i[DIV_STEPS-2:0], ge};
		dvs_o <= dvs_i;
	end

endmodule

/* hdl/rotation_matrix_to_theta_u.sv */
`timescale 1ns / 1ps
// Top level: rotation matrix to theta-u vector, fully pipelined cell chains.
//
//  channel   handshake           payload                         width
//  request   start / busy        r00 r01 r02 r10 r11 r12 r20..r22  18 signed each
//  result    done (strobe)       tu_x tu_y tu_z                  19 signed each
//                                near_pi                         1
//
// One request per cycle; busy is always low. Each request passes through 20
// root cells for the skew length, 18 CORDIC cells, 40 divider cells and 20
// more root cells for the near-pi ratio, plus 8 setup and output stages.
// Reset clears only the valid line; the receiver cannot stall the result.
module rotation_matrix_to_theta_u (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r00,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r01,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r02,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r10,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r11,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r12,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r20,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r21,
	input  logic signed [rm2tu_pkg::IN_W-1:0] r22,
	output logic                              done,
	output logic signed [rm2tu_pkg::OUT_W-1:0] tu_x,
	output logic signed [rm2tu_pkg::OUT_W-1:0] tu_y,
	output logic signed [rm2tu_pkg::OUT_W-1:0] tu_z,
	output logic                              near_pi
);
	import rm2tu_pkg::*;

	localparam int LAT    = 8 + 2 * SQRT_STEPS + CORDIC_STEPS + DIV_STEPS;
	localparam int TH_IDX = 4 + SQRT_STEPS + CORDIC_STEPS;

	// how each output magnitude is formed
	typedef enum logic [2:0] {
		MAG_ZERO,
		MAG_TINY,
		MAG_FULL,
		MAG_QUOT,
		MAG_ROOT
	} mag_mode_t;

	typedef struct packed {
		logic [2:0][D_W-1:0] d;
		logic [2:0][21:0]    a;
		logic [20:0]         b;
		logic [20:0]         tm1;
		logic                near;
	} geo_t;

	typedef struct packed {
		geo_t              g;
		logic [ROOT_W-1:0] s2;
	} cgeo_t;

	typedef struct packed {
		logic [2:0]           neg;
		logic [2:0][D_W-1:0]  absd;
		mag_mode_t [2:0]      mode;
		logic [TH_W-1:0]      theta;
		logic                 near;
	} lane_t;

	typedef struct packed {
		lane_t                ln;
		logic [2:0][TH_W-1:0] quo;
	} rlane_t;

	logic            acc;
	logic [LAT-1:0]  vld_q;

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	// advance the valid line every cycle; the data path never stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end

	// ---- stage 1: skew differences, trace, diagonal terms, branch pick ----
	logic signed [20:0] trace_c, tm1_c, tpo_c;
	logic signed [35:0] npc_c;
	logic               near_c;
	geo_t               g_s1, g_s2, g_s3;

	always_comb begin
		trace_c = 21'(r00) + 21'(r11) + 21'(r22);
		tm1_c   = trace_c - 21'(ONE);
		tpo_c   = trace_c + 21'(ONE);
		npc_c   = 36'(tpo_c) * 36'sd5000;
		// general branch while 1+c exceeds about 1e-4
		near_c  = !(npc_c > 36'(ONE));
	end

	always_ff @(posedge clk) begin
		g_s1.d[0] <= 19'(r21) - 19'(r12);
		g_s1.d[1] <= 19'(r02) - 19'(r20);
		g_s1.d[2] <= 19'(r10) - 19'(r01);
		g_s1.a[0] <= (22'(r00) <<< 1) - 22'(tm1_c);
		g_s1.a[1] <= (22'(r11) <<< 1) - 22'(tm1_c);
		g_s1.a[2] <= (22'(r22) <<< 1) - 22'(tm1_c);
		g_s1.b    <= 21'(3 * ONE) - trace_c;
		g_s1.tm1  <= tm1_c;
		g_s1.near <= near_c;
	end

	// ---- stage 2: squares of the skew differences ----
	logic signed [37:0] p_c [3];
	logic [SQ_W-1:0]    sq_s2 [3];

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			p_c[n] = $signed(g_s1.d[n]) * $signed(g_s1.d[n]);
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			sq_s2[n] <= p_c[n][SQ_W-1:0];
		end
		g_s2 <= g_s1;
	end

	// ---- stage 3: sum of squares ----
	logic [RAD_W-1:0] ss_s3;

	always_ff @(posedge clk) begin
		ss_s3 <= RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2]);
		g_s3  <= g_s2;
	end

	// ---- root chain: s2 = isqrt(sum of squares), twice the sine ----
	logic [RAD_W-1:0]  sq_rem  [SQRT_STEPS+1];
	logic [ROOT_W-1:0] sq_root [SQRT_STEPS+1];
	geo_t              sq_sb_s [SQRT_STEPS+1];

	assign sq_rem[0]  = ss_s3;
	assign sq_root[0] = '0;
	assign sq_sb_s[0] = g_s3;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sq
		rm2tu_sqrt_cell u_cell (
			.clk    (clk),
			.k      (5'(SQRT_STEPS - 1 - j)),
			.rem_i  (sq_rem[j]),
			.root_i (sq_root[j]),
			.rem_o  (sq_rem[j+1]),
			.root_o (sq_root[j+1])
		);
		always_ff @(posedge clk) begin
			sq_sb_s[j+1] <= sq_sb_s[j];
		end
	end

	// ---- stage 4: CORDIC setup, fold the left half plane by pi/2 ----
	logic signed [X_W-1:0] xa_c, ya_c;
	logic signed [X_W-1:0] cd_x [CORDIC_STEPS+1];
	logic signed [X_W-1:0] cd_y [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] cd_z [CORDIC_STEPS+1];
	cgeo_t                 cd_sb_s [CORDIC_STEPS+1];
	logic signed [X_W-1:0] x_s4, y_s4;
	logic signed [Z_W-1:0] z_s4;
	cgeo_t                 c_s4;

	always_comb begin
		xa_c = X_W'($signed(sq_sb_s[SQRT_STEPS].tm1)) <<< GSHIFT;
		ya_c = $signed(X_W'(sq_root[SQRT_STEPS]) << GSHIFT);
	end

	always_ff @(posedge clk) begin
		if (xa_c < 0) begin
			x_s4 <= ya_c;
			y_s4 <= -xa_c;
			z_s4 <= $signed(Z_W'(HALF_PI_Q30));
		end else begin
			x_s4 <= xa_c;
			y_s4 <= ya_c;
			z_s4 <= '0;
		end
		c_s4.g  <= sq_sb_s[SQRT_STEPS];
		c_s4.s2 <= sq_root[SQRT_STEPS];
	end

	assign cd_x[0]    = x_s4;
	assign cd_y[0]    = y_s4;
	assign cd_z[0]    = z_s4;
	assign cd_sb_s[0] = c_s4;

	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cd
		rm2tu_cordic_cell u_cell (
			.clk (clk),
			.i   (5'(j)),
			.x_i (cd_x[j]),
			.y_i (cd_y[j]),
			.z_i (cd_z[j]),
			.x_o (cd_x[j+1]),
			.y_o (cd_y[j+1]),
			.z_o (cd_z[j+1])
		);
		always_ff @(posedge clk) begin
			cd_sb_s[j+1] <= cd_sb_s[j];
		end
	end

	// ---- stage 5: clamp theta to [0, pi] ----
	logic signed [Z_W-1:0] zf_c;
	logic [TH_W-1:0]       th_s5;
	cgeo_t                 c_s5;

	assign zf_c = cd_z[CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (zf_c < 0) begin
			th_s5 <= '0;
		end else if (zf_c > $signed(Z_W'(PI_Q30))) begin
			th_s5 <= PI_Q30;
		end else begin
			th_s5 <= zf_c[TH_W-1:0];
		end
		c_s5 <= cd_sb_s[CORDIC_STEPS];
	end

	// ---- stage 6: per-axis operands for the per-axis divider chains ----
	// general: |d|*theta / s2; near pi: a*2^40 / b; otherwise a dummy 0/1
	logic [DVD_W-1:0]      dvd_c [3];
	logic [DVS_W-1:0]      dvs_c [3];
	lane_t                 ln_c;
	logic                  tiny_c;
	logic signed [D_W-1:0] dl_c;
	logic signed [21:0]    al_c;
	logic signed [20:0]    bl_c;

	logic [REM_W-1:0]     dv_rem [3][DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_lo  [3][DIV_STEPS+1];
	logic [DVS_W-1:0]     dv_dvs [3][DIV_STEPS+1];
	lane_t                dv_sb_s [DIV_STEPS+1];
	logic [REM_W-1:0]     rem_s6 [3];
	logic [DIV_STEPS-1:0] lo_s6  [3];
	logic [DVS_W-1:0]     dvs_s6 [3];
	lane_t                ln_s6;

	always_comb begin
		// sinc taken as one for a tiny angle or a zero skew part
		tiny_c = (({27'b0, th_s5} * 59'd100000000) < (59'd1 << 30)) || (c_s5.s2 == '0);
		bl_c   = $signed(c_s5.g.b);
		ln_c.theta = th_s5;
		ln_c.near  = c_s5.g.near;
		for (int n = 0; n < 3; n++) begin
			dl_c = $signed(c_s5.g.d[n]);
			al_c = $signed(c_s5.g.a[n]);
			ln_c.neg[n]  = dl_c < 0;
			ln_c.absd[n] = (dl_c < 0) ? D_W'(-dl_c) : D_W'(dl_c);
			ln_c.mode[n] = MAG_ZERO;
			dvd_c[n] = '0;
			dvs_c[n] = DVS_W'(1);
			if (!c_s5.g.near) begin
				if (tiny_c) begin
					ln_c.mode[n] = MAG_TINY;
				end else begin
					ln_c.mode[n] = MAG_QUOT;
					dvd_c[n] = ln_c.absd[n] * th_s5;
					dvs_c[n] = c_s5.s2;
				end
			end else if (al_c <= 0) begin
				ln_c.mode[n] = MAG_ZERO;
			end else if (bl_c <= 0 || al_c >= bl_c) begin
				ln_c.mode[n] = MAG_FULL;
			end else begin
				ln_c.mode[n] = MAG_ROOT;
				dvd_c[n] = {al_c[19:0], 40'b0};
				dvs_c[n] = bl_c[DVS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			rem_s6[n] <= dvd_c[n][DVD_W-1:DIV_STEPS];
			lo_s6[n]  <= dvd_c[n][DIV_STEPS-1:0];
			dvs_s6[n] <= dvs_c[n];
		end
		ln_s6 <= ln_c;
	end

	assign dv_sb_s[0] = ln_s6;

	for (genvar l = 0; l < 3; l++) begin : g_dl
		assign dv_rem[l][0] = rem_s6[l];
		assign dv_lo[l][0]  = lo_s6[l];
		assign dv_dvs[l][0] = dvs_s6[l];
		for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
			rm2tu_div_cell u_cell (
				.clk   (clk),
				.rem_i (dv_rem[l][j]),
				.lo_i  (dv_lo[l][j]),
				.dvs_i (dv_dvs[l][j]),
				.rem_o (dv_rem[l][j+1]),
				.lo_o  (dv_lo[l][j+1]),
				.dvs_o (dv_dvs[l][j+1])
			);
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dvsb
		always_ff @(posedge clk) begin
			dv_sb_s[j+1] <= dv_sb_s[j];
		end
	end

	// ---- root chain on the near-pi ratio, general quotient rides along ----
	logic [RAD_W-1:0]  rt_rem  [3][SQRT_STEPS+1];
	logic [ROOT_W-1:0] rt_root [3][SQRT_STEPS+1];
	rlane_t            rt_sb_s [SQRT_STEPS+1];

	assign rt_sb_s[0].ln = dv_sb_s[DIV_STEPS];

	for (genvar l = 0; l < 3; l++) begin : g_rl
		assign rt_rem[l][0]       = RAD_W'(dv_lo[l][DIV_STEPS]);
		assign rt_root[l][0]      = '0;
		assign rt_sb_s[0].quo[l]  = dv_lo[l][DIV_STEPS][TH_W-1:0];
		for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_rt
			rm2tu_sqrt_cell u_cell (
				.clk    (clk),
				.k      (5'(SQRT_STEPS - 1 - j)),
				.rem_i  (rt_rem[l][j]),
				.root_i (rt_root[l][j]),
				.rem_o  (rt_rem[l][j+1]),
				.root_o (rt_root[l][j+1])
			);
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_rtsb
		always_ff @(posedge clk) begin
			rt_sb_s[j+1] <= rt_sb_s[j];
		end
	end

	// ---- stage 7: wide magnitude per axis ----
	rlane_t           rf_c;
	logic [MAG_W-1:0] mag_c  [3];
	logic [MAG_W-1:0] prod_c [3];
	logic [MAG_W-1:0] mag_s7 [3];
	logic [2:0]       big_s7, neg_s7;
	logic             near_s7;

	assign rf_c = rt_sb_s[SQRT_STEPS];

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			prod_c[n] = rf_c.ln.theta * rt_root[n][SQRT_STEPS];
			case (rf_c.ln.mode[n])
				MAG_TINY: mag_c[n] = MAG_W'(rf_c.ln.absd[n]) << (TH_W - 3);
				MAG_FULL: mag_c[n] = MAG_W'(rf_c.ln.theta) << 20;
				MAG_QUOT: mag_c[n] = MAG_W'(rf_c.quo[n]);
				MAG_ROOT: mag_c[n] = prod_c[n];
				default:  mag_c[n] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			mag_s7[n] <= mag_c[n];
			big_s7[n] <= (rf_c.ln.mode[n] == MAG_FULL) || (rf_c.ln.mode[n] == MAG_ROOT);
		end
		neg_s7  <= rf_c.ln.neg;
		near_s7 <= rf_c.ln.near;
	end

	// ---- stage 8: round half up, saturate at pi, apply sign ----
	logic [MAG_W:0]       rnd_c [3];
	logic [OUT_W-2:0]     sat_c [3];
	logic signed [OUT_W-1:0] out_c [3];
	logic signed [OUT_W-1:0] tu_s8 [3];
	logic                 near_s8;

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			if (big_s7[n]) begin
				rnd_c[n] = ({1'b0, mag_s7[n]} + ((MAG_W+1)'(1) << (NSHIFT - 1))) >> NSHIFT;
			end else begin
				rnd_c[n] = ({1'b0, mag_s7[n]} + ((MAG_W+1)'(1) << (GSHIFT - 1))) >> GSHIFT;
			end
			sat_c[n] = (rnd_c[n] > (MAG_W+1)'(TU_MAX)) ? TU_MAX : rnd_c[n][OUT_W-2:0];
			out_c[n] = neg_s7[n] ? -$signed({1'b0, sat_c[n]}) : $signed({1'b0, sat_c[n]});
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			tu_s8[n] <= out_c[n];
		end
		near_s8 <= near_s7;
	end

	assign done    = vld_q[LAT-1];
	assign tu_x    = tu_s8[0];
	assign tu_y    = tu_s8[1];
	assign tu_z    = tu_s8[2];
	assign near_pi = near_s8;

`ifndef SYNTHESIS
	a_theta_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[TH_IDX] |-> (th_s5 <= PI_Q30))
		else $error("theta left [0, pi]");
	a_tu_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tu_x <= $signed({1'b0, TU_MAX}) && tu_x >= -$signed({1'b0, TU_MAX})))
		else $error("tu_x beyond pi");
	a_tu_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tu_y <= $signed({1'b0, TU_MAX}) && tu_y >= -$signed({1'b0, TU_MAX})))
		else $error("tu_y beyond pi");
	a_tu_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tu_z <= $signed({1'b0, TU_MAX}) && tu_z >= -$signed({1'b0, TU_MAX})))
		else $error("tu_z beyond pi");
`endif

endmodule

/* test/rotation_matrix_to_theta_u_test.sv */
`timescale 1ns / 1ps
// Testbench: rotation matrix to theta-u converter, checked against an in-bench predictor.
module rotation_matrix_to_theta_u_test;
	import rm2tu_pkg::*;

	typedef logic signed [IN_W-1:0] elem_t;
	typedef elem_t mat_t [9];

	typedef struct packed {
		logic [OUT_W-1:0] tu_x;
		logic [OUT_W-1:0] tu_y;
		logic [OUT_W-1:0] tu_z;
		logic             near_pi;
	} theta_u_t;

	// Pipeline latency (end-of-run settle time) and the watchdog limit.
	localparam int LATENCY     = 106;
	localparam int CYCLE_LIMIT = 400000;

	// atan(2^-i) in Q30, rounded to nearest
	localparam longint ARCTAN_Q30 [32] = '{
		843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437,
		4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048,
		1024, 512, 256, 128,
		64, 32, 16, 8,
		4, 2, 1, 0
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic done;
	logic signed [OUT_W-1:0] tu_x, tu_y, tu_z;
	logic near_pi;

	theta_u_t pending_tu [$];
	bit       failed;
	bit       idle_on;
	int       cycles;

	rotation_matrix_to_theta_u dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.done(done), .tu_x(tu_x), .tu_y(tu_y), .tu_z(tu_z), .near_pi(near_pi)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Integer square root, floor, bit by bit.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Round the magnitude half up, saturate to pi, apply the sign last.
	function automatic logic [OUT_W-1:0] round_sat(input bit neg, input longint unsigned mag,
			input int sh);
		longint unsigned m;
		m = (sh == 0) ? mag : (mag + (64'd1 << (sh - 1))) >> sh;
		if (m > longint'(TU_MAX))
			m = longint'(TU_MAX);
		if (neg)
			m = -m;
		return m[OUT_W-1:0];
	endfunction

	function automatic theta_u_t predict_theta_u(input mat_t m);
		longint r [9];
		longint d [3];
		longint diag [3];
		longint trace, tm1, x, y, z, xs, ys, t, a, b;
		longint unsigned ss, s2, theta, mag, q;
		logic [OUT_W-1:0] comp [3];
		bit tiny;
		theta_u_t res;
		for (int i = 0; i < 9; i++)
			r[i] = longint'(m[i]);
		d[0] = r[7] - r[5];
		d[1] = r[2] - r[6];
		d[2] = r[3] - r[1];
		diag[0] = r[0];
		diag[1] = r[4];
		diag[2] = r[8];
		ss = longint'(d[0] * d[0]) + longint'(d[1] * d[1]) + longint'(d[2] * d[2]);
		s2 = int_sqrt(ss);
		trace = r[0] + r[4] + r[8];
		tm1 = trace - ONE;

		// atan2(2s, 2c): pre-rotate into the right half plane, then vector to y = 0
		x = tm1 * (longint'(1) << GSHIFT);
		y = longint'(s2) * (longint'(1) << GSHIFT);
		z = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = longint'(HALF_PI_Q30);
		end
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += ARCTAN_Q30[i];
			end else if (y < 0) begin
				x -= ys;
				y += xs;
				z -= ARCTAN_Q30[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > longint'(PI_Q30))
			z = longint'(PI_Q30);
		theta = z;

		if ((trace + ONE) * 5000 > ONE) begin
			// general branch; sinc is 1 for a tiny angle or a zero skew part
			tiny = (theta * 64'd100000000 < (64'd1 << 30)) || s2 == 0;
			for (int i = 0; i < 3; i++) begin
				mag = (d[i] < 0) ? -d[i] : d[i];
				q = tiny ? (mag << 29) : (mag * theta) / s2;
				comp[i] = round_sat(d[i] < 0, q, GSHIFT);
			end
			res.near_pi = 1'b0;
		end else begin
			// near pi: theta * sqrt((Rii - c) / (1 - c)), signed by the skew difference
			b = 3 * ONE - trace;
			for (int i = 0; i < 3; i++) begin
				a = 2 * diag[i] - tm1;
				if (a <= 0)
					mag = 0;
				else if (b <= 0 || a >= b)
					mag = theta << 20;
				else
					mag = theta * int_sqrt((longint'(a) << 40) / longint'(b));
				comp[i] = round_sat(d[i] < 0, mag, NSHIFT);
			end
			res.near_pi = 1'b1;
		end
		res.tu_x = comp[0];
		res.tu_y = comp[1];
		res.tu_z = comp[2];
		return res;
	endfunction

	// Drive one request and hold it until accepted; then maybe idle for a burst.
	task automatic send_matrix(input mat_t m);
		start <= 1'b1;
		r00 <= m[0]; r01 <= m[1]; r02 <= m[2];
		r10 <= m[3]; r11 <= m[4]; r12 <= m[5];
		r20 <= m[6]; r21 <= m[7]; r22 <= m[8];
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_tu.insert(pending_tu.size(), predict_theta_u(m));
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drop start and hold off until every outstanding result is back.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_tu.size() != 0)
			@(posedge clk);
	endtask

	function automatic elem_t to_q16(input real v);
		int q;
		q = $rtoi(v * 65536.0 + (v >= 0.0 ? 0.5 : -0.5));
		if (q > 65536)
			q = 65536;
		if (q < -65536)
			q = -65536;
		return elem_t'(q);
	endfunction

	// Build a quantized rotation from an axis and an angle.
	function automatic mat_t axis_angle(input real ux, input real uy, input real uz,
			input real ang);
		real n, c, s, v;
		mat_t m;
		n = $sqrt(ux * ux + uy * uy + uz * uz);
		ux = ux / n;
		uy = uy / n;
		uz = uz / n;
		c = $cos(ang);
		s = $sin(ang);
		v = 1.0 - c;
		m[0] = to_q16(c + ux * ux * v);
		m[1] = to_q16(ux * uy * v - uz * s);
		m[2] = to_q16(ux * uz * v + uy * s);
		m[3] = to_q16(uy * ux * v + uz * s);
		m[4] = to_q16(c + uy * uy * v);
		m[5] = to_q16(uy * uz * v - ux * s);
		m[6] = to_q16(uz * ux * v - uy * s);
		m[7] = to_q16(uz * uy * v + ux * s);
		m[8] = to_q16(c + uz * uz * v);
		return m;
	endfunction

	function automatic real rand_unit();
		return ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
	endfunction

	function automatic mat_t rand_pose();
		real ux, uy, uz, ang, pi_r;
		mat_t m;
		pi_r = 3.14159265358979;
		do begin
			ux = rand_unit();
			uy = rand_unit();
			uz = rand_unit();
		end while (ux * ux + uy * uy + uz * uz < 0.01);
		case ($urandom_range(0, 3))
			0: ang = pi_r - $itor($urandom_range(0, 1000)) * 1.0e-5;
			1: ang = $itor($urandom_range(0, 1000)) * 1.0e-5;
			default: ang = pi_r * $itor($urandom_range(0, 100000)) / 100000.0;
		endcase
		m = axis_angle(ux, uy, uz, ang);
		// perturb a few lsbs now and then
		if ($urandom_range(0, 3) == 0)
			foreach (m[i])
				m[i] = m[i] + elem_t'($signed($urandom_range(0, 6)) - 3);
		return m;
	endfunction

	// Noise: full-width or in-range random elements.
	function automatic mat_t rand_noise();
		mat_t m;
		bit wide;
		wide = $urandom_range(0, 1);
		foreach (m[i])
			m[i] = wide ? elem_t'($urandom()) : elem_t'($signed($urandom_range(0, 131072)) - 65536);
		return m;
	endfunction

	task automatic test_directed();
		mat_t m;
		real pi_r;
		pi_r = 3.14159265358979;
		// identity: zero skew, zero angle
		m = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
		send_matrix(m);
		// quarter turns about each axis
		send_matrix(axis_angle(1.0, 0.0, 0.0, pi_r / 2.0));
		send_matrix(axis_angle(0.0, 1.0, 0.0, -pi_r / 2.0));
		send_matrix(axis_angle(0.0, 0.0, 1.0, pi_r / 2.0));
		// half turns: near-pi branch, zero skew, non-positive diagonal terms
		m = '{65536, 0, 0, 0, -65536, 0, 0, 0, -65536};
		send_matrix(m);
		m = '{-65536, 0, 0, 0, 65536, 0, 0, 0, -65536};
		send_matrix(m);
		m = '{-65536, 0, 0, 0, -65536, 0, 0, 0, 65536};
		send_matrix(m);
		// close to pi, both skew signs
		send_matrix(axis_angle(1.0, -1.0, 1.0, pi_r - 0.001));
		send_matrix(axis_angle(-1.0, 1.0, -1.0, pi_r - 0.001));
		// tiny angle
		send_matrix(axis_angle(0.3, 0.5, -0.8, 1.0e-6));
		m = '{65536, -1, 0, 1, 65536, 0, 0, 0, 65536};
		send_matrix(m);
		// extremes of the element range, in range and full width
		m = '{65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536};
		send_matrix(m);
		m = '{-65536, -65536, -65536, -65536, -65536, -65536, -65536, -65536, -65536};
		send_matrix(m);
		m = '{131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071};
		send_matrix(m);
		m = '{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072};
		send_matrix(m);
		m = '{0, -131072, 131071, 131071, 0, -131072, -131072, 131071, 0};
		send_matrix(m);
		// diagonal sum below -1 with skew: near-pi ratio below one
		m = '{-65536, 30000, 0, -30000, -65536, 0, 0, 0, -65536};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
	endtask

	task automatic test_random_poses(input int count);
		for (int i = 0; i < count; i++)
			send_matrix(($urandom_range(0, 4) == 0) ? rand_noise() : rand_pose());
	endtask

	// Check each result against the oldest prediction, field by field.
	task automatic check_field(input string name, input logic [OUT_W-1:0] exp_v,
			input logic [OUT_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name,
				$signed(exp_v), $signed(act_v));
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		theta_u_t want;
		if (arst_n && done) begin
			if (pending_tu.size() == 0) begin
				$display("%0t unexpected result: tu %0d %0d %0d near_pi %0b", $time,
					tu_x, tu_y, tu_z, near_pi);
				failed = 1'b1;
			end else begin
				want = pending_tu.pop_front();
				check_field("tu_x", want.tu_x, tu_x);
				check_field("tu_y", want.tu_y, tu_y);
				check_field("tu_z", want.tu_z, tu_z);
				check_field("near_pi", {{(OUT_W-1){1'b0}}, want.near_pi},
					{{(OUT_W-1){1'b0}}, near_pi});
			end
		end
	end

	// Advance the watchdog; end the run on a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		idle_on = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{r00, r01, r02, r10, r11, r12, r20, r21, r22} = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// hold off until the pipeline is empty at least once
		drain_results();
		idle_on = 1'b1;
		test_random_poses(700);
		drain_results();
		// back-to-back requests, no idling, to finish
		idle_on = 1'b0;
		test_random_poses(300);
		start <= 1'b0;

		while (pending_tu.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
